/* rtl/core/cls_pkg.sv */
// types, codes and parse functions for the command line splitter
// used by every module of the block; depends on nothing
package cls_pkg;

  // parser states
  localparam logic [3:0] ST_OUT   = 4'd0;
  localparam logic [3:0] ST_UNQ   = 4'd1;
  localparam logic [3:0] ST_QUO   = 4'd2;
  localparam logic [3:0] ST_BSU   = 4'd3;
  localparam logic [3:0] ST_BSQ   = 4'd4;
  localparam logic [3:0] ST_AFTQ  = 4'd5;
  localparam logic [3:0] ST_A0BEG = 4'd6;
  localparam logic [3:0] ST_A0UNQ = 4'd7;
  localparam logic [3:0] ST_A0QUO = 4'd8;

  localparam logic [20:0] CH_BSL   = 21'h5c;
  localparam logic [20:0] CH_QUOTE = 21'h22;
  localparam logic [20:0] CH_SPACE = 21'h20;
  localparam logic [20:0] CH_TAB   = 21'h09;
  localparam logic [5:0]  SUR_HI   = 6'h36;
  localparam logic [5:0]  SUR_LO   = 6'h37;
  localparam logic [14:0] SAT_MAX  = 15'h7fff;

  localparam int SLOTS = 8;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [14:0] rep;
  } item_t;

  // all results caused by one input item
  typedef struct packed {
    item_t [SLOTS-1:0] items;
    logic [3:0]        n;
    logic              done;
    logic [14:0]       count;
  } bundle_t;

  // parser context while one item is worked out
  typedef struct packed {
    logic [3:0]        st;
    logic [14:0]       run;
    logic [14:0]       cnt;
    item_t [SLOTS-1:0] items;
    logic [3:0]        n;
  } ctx_t;

  function automatic ctx_t add(ctx_t c, logic k, logic [7:0] b, logic [14:0] r);
    ctx_t o;
    o = c;
    if (o.n < 4'(SLOTS)) begin
      o.items[o.n[2:0]] = '{kind: k, byte_value: b, rep: r};
      o.n = o.n + 4'd1;
    end
    return o;
  endfunction

  function automatic ctx_t encode(ctx_t c, logic [20:0] cp);
    ctx_t o;
    o = c;
    if (cp < 21'h80) begin
      o = add(o, 1'b0, cp[7:0], 15'd1);
    end else if (cp < 21'h800) begin
      o = add(o, 1'b0, {3'b110, cp[10:6]}, 15'd1);
      o = add(o, 1'b0, {2'b10, cp[5:0]}, 15'd1);
    end else if (cp < 21'h10000) begin
      o = add(o, 1'b0, {4'he, cp[15:12]}, 15'd1);
      o = add(o, 1'b0, {2'b10, cp[11:6]}, 15'd1);
      o = add(o, 1'b0, {2'b10, cp[5:0]}, 15'd1);
    end else begin
      o = add(o, 1'b0, {5'b11110, cp[20:18]}, 15'd1);
      o = add(o, 1'b0, {2'b10, cp[17:12]}, 15'd1);
      o = add(o, 1'b0, {2'b10, cp[11:6]}, 15'd1);
      o = add(o, 1'b0, {2'b10, cp[5:0]}, 15'd1);
    end
    return o;
  endfunction

  function automatic ctx_t emit_run(ctx_t c);
    ctx_t o;
    o = c;
    if (o.run != 15'd0) o = add(o, 1'b0, CH_BSL[7:0], o.run);
    o.run = 15'd0;
    return o;
  endfunction

  // states that decide in one step
  function automatic ctx_t step_simple(ctx_t c, logic [20:0] ch);
    ctx_t o;
    logic blank;
    o = c;
    blank = (ch == CH_SPACE) || (ch == CH_TAB);
    case (o.st)
      ST_UNQ: begin
        if (blank) begin
          o = add(o, 1'b0, 8'd0, 15'd1);
          o.st = ST_OUT;
        end else if (ch == CH_QUOTE) o.st = ST_QUO;
        else if (ch == CH_BSL) begin
          o.run = 15'd1;
          o.st = ST_BSU;
        end else o = encode(o, ch);
      end
      ST_QUO: begin
        if (ch == CH_QUOTE) o.st = ST_AFTQ;
        else if (ch == CH_BSL) begin
          o.run = 15'd1;
          o.st = ST_BSQ;
        end else o = encode(o, ch);
      end
      ST_A0BEG: begin
        if (blank) begin
          o = add(o, 1'b0, 8'd0, 15'd1);
          o.st = ST_OUT;
        end else if (ch == CH_QUOTE) o.st = ST_A0QUO;
        else begin
          o.st = ST_A0UNQ;
          o = encode(o, ch);
        end
      end
      ST_A0UNQ: begin
        if (blank) begin
          o = add(o, 1'b0, 8'd0, 15'd1);
          o.st = ST_OUT;
        end else o = encode(o, ch);
      end
      ST_A0QUO: begin
        if (ch == CH_QUOTE) begin
          o = add(o, 1'b0, 8'd0, 15'd1);
          o.st = ST_OUT;
        end else o = encode(o, ch);
      end
      default: begin
        o.st = ST_OUT;
        if (!blank) begin
          o = add(o, 1'b1, 8'd0, 15'd0);
          if (o.cnt < SAT_MAX) o.cnt = o.cnt + 15'd1;
          if (ch == CH_QUOTE) o.st = ST_QUO;
          else if (ch == CH_BSL) begin
            o.run = 15'd1;
            o.st = ST_BSU;
          end else begin
            o.st = ST_UNQ;
            o = encode(o, ch);
          end
        end
      end
    endcase
    return o;
  endfunction

  // one code point through the parser, at most two state steps
  function automatic ctx_t process(ctx_t c, logic [20:0] ch);
    ctx_t o;
    logic again;
    logic odd;
    o = c;
    again = 1'b0;
    odd = 1'b0;
    case (o.st)
      ST_BSU, ST_BSQ: begin
        if (ch == CH_BSL) begin
          if (o.run < SAT_MAX) o.run = o.run + 15'd1;
        end else begin
          o.st = o.st - 4'd2;
          if (ch == CH_QUOTE) begin
            odd = o.run[0];
            o.run = o.run >> 1;
            o = emit_run(o);
            if (odd) o = encode(o, ch);
            else again = 1'b1;
          end else begin
            o = emit_run(o);
            again = 1'b1;
          end
        end
      end
      ST_AFTQ: begin
        o.st = ST_UNQ;
        if (ch == CH_QUOTE) o = encode(o, ch);
        else again = 1'b1;
      end
      default: again = 1'b1;
    endcase
    if (again) o = step_simple(o, ch);
    return o;
  endfunction

endpackage

/* rtl/core/cls_front.sv */
// front end: parser state, surrogate pairing and per-item result bundles
// depends on cls_pkg
module cls_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [15:0]       code_unit,
  output logic              bun_valid,
  output cls_pkg::bundle_t  bun
);

  logic [3:0]  st_r;
  logic [14:0] run_r;
  logic [14:0] cnt_r;
  logic        ph_v_r;
  logic [9:0]  ph_u_r;

  cls_pkg::ctx_t ctx;
  logic          ph_v_nxt;
  logic          done;
  logic [14:0]   done_cnt;

  // decide one code unit
  always_comb begin
    logic consumed;
    ctx = '0;
    ctx.st = st_r;
    ctx.run = run_r;
    ctx.cnt = cnt_r;
    consumed = 1'b0;
    ph_v_nxt = ph_v_r;
    done = 1'b0;
    done_cnt = '0;
    if (ph_v_r) begin
      ph_v_nxt = 1'b0;
      if (code_unit[15:10] == cls_pkg::SUR_LO) begin
        ctx = cls_pkg::process(ctx, 21'h10000 + {1'b0, ph_u_r, code_unit[9:0]});
        consumed = 1'b1;
      end else begin
        ctx = cls_pkg::process(ctx, {5'd0, cls_pkg::SUR_HI, ph_u_r});
      end
    end
    if (!consumed) begin
      if (code_unit == 16'd0) begin
        if (ctx.st == cls_pkg::ST_BSU || ctx.st == cls_pkg::ST_BSQ)
          ctx = cls_pkg::emit_run(ctx);
        if (ctx.st == cls_pkg::ST_OUT) ctx = cls_pkg::add(ctx, 1'b0, 8'd0, 15'd0);
        else ctx = cls_pkg::add(ctx, 1'b0, 8'd0, 15'd1);
        done = 1'b1;
        done_cnt = ctx.cnt;
      end else if (code_unit[15:10] == cls_pkg::SUR_HI) begin
        ph_v_nxt = 1'b1;
      end else begin
        ctx = cls_pkg::process(ctx, {5'd0, code_unit});
      end
    end
  end

  assign bun_valid = fire && (ctx.n != 4'd0);
  assign bun = '{items: ctx.items, n: ctx.n, done: done, count: done_cnt};

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cls_pkg::ST_A0BEG;
      run_r <= '0;
      cnt_r <= 15'd1;
      ph_v_r <= 1'b0;
      ph_u_r <= '0;
    end else if (fire) begin
      if (done) begin
        st_r <= cls_pkg::ST_A0BEG;
        run_r <= '0;
        cnt_r <= 15'd1;
        ph_v_r <= 1'b0;
      end else begin
        st_r <= ctx.st;
        run_r <= ctx.run;
        cnt_r <= ctx.cnt;
        ph_v_r <= ph_v_nxt;
      end
      ph_u_r <= code_unit[9:0];
    end
  end

endmodule

/* rtl/core/cls_queue.sv */
// four-entry queue of result bundles between front and back
// depends on cls_pkg
module cls_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  cls_pkg::bundle_t  wr_data,
  input  logic              rd,
  output logic              full,
  output logic              nonempty,
  output cls_pkg::bundle_t  rd_data
);

  cls_pkg::bundle_t mem [4];
  logic [1:0] wp_r;
  logic [1:0] rp_r;
  logic [2:0] cnt_r;

  assign full = (cnt_r == 3'd4);
  assign nonempty = (cnt_r != 3'd0);
  assign rd_data = mem[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr} - {2'd0, rd};
    end
  end

endmodule

/* rtl/core/cls_back.sv */
// back end: walks each bundle into the output register one item per cycle
// while that register is empty or popped; depends on cls_pkg
module cls_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  cls_pkg::bundle_t  q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic              kind,
  output logic [7:0]        byte_value,
  output logic [14:0]       repeat_res,
  output logic              line_done,
  output logic [14:0]       arg_count,
  output logic              last
);

  logic       ov_r;
  logic [2:0] idx_r;
  logic       load;
  logic       is_last;
  cls_pkg::item_t cur;

  assign load = !ov_r || pop;
  assign cur = q_data.items[idx_r];
  assign is_last = ({1'b0, idx_r} == q_data.n - 4'd1);
  assign q_rd = load && q_nonempty && is_last;
  assign empty = !ov_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      ov_r <= q_nonempty;
      if (q_nonempty) idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && q_nonempty) begin
      kind <= cur.kind;
      byte_value <= cur.byte_value;
      repeat_res <= cur.rep;
      line_done <= is_last && q_data.done;
      arg_count <= (is_last && q_data.done) ? q_data.count : 15'd0;
      last <= is_last;
    end
  end

endmodule

/* rtl/core/command_line_splitter_utf16_to_utf8.sv */
// top level of the command line splitter
// depends on cls_pkg, cls_front, cls_queue and cls_back
//
// Input: one UTF-16 code unit per item on in_code_unit, taken when in_push is
// high and in_full is low; a unit of 0 ends the line. Output: WTF-8 byte runs
// and argument-start markers, shown while out_empty is low and taken with
// out_pop. out_last marks the final item caused by one input item, and
// out_line_done with out_arg_count closes a line.
// The front parser decides one code unit per cycle while the queue has room and
// writes all items it causes as one bundle into a four-entry queue. The back end
// sends one item per cycle from the queue head through an output register while
// the receiver pops, so the first item of an input item passes a queue entry and
// then the output register, and a stream sustains one input item per cycle while
// each causes at most one item; units that expand to several bytes send their
// items one after another. A stalled receiver holds the output register; input
// keeps flowing until the queue fills. Synchronous reset empties queue and output
// and returns the parser to the start of argument 0; no clearing pass is needed.
module command_line_splitter_utf16_to_utf8 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_code_unit,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [7:0]  out_byte_value,
  output logic [14:0] out_repeat_res,
  output logic        out_line_done,
  output logic [14:0] out_arg_count,
  output logic        out_last
);

  logic             fire;
  logic             bun_valid;
  cls_pkg::bundle_t bun;
  cls_pkg::bundle_t q_data;
  logic             q_nonempty;
  logic             q_rd;

  assign fire = in_push && !in_full;

  cls_front u_front (
    .clk(clk), .rst_n(rst_n), .fire(fire), .code_unit(in_code_unit),
    .bun_valid(bun_valid), .bun(bun)
  );

  cls_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(bun_valid), .wr_data(bun), .rd(q_rd),
    .full(in_full), .nonempty(q_nonempty), .rd_data(q_data)
  );

  cls_back u_back (
    .clk(clk), .rst_n(rst_n), .q_nonempty(q_nonempty), .q_data(q_data),
    .q_rd(q_rd), .pop(out_pop), .empty(out_empty), .kind(out_kind),
    .byte_value(out_byte_value), .repeat_res(out_repeat_res),
    .line_done(out_line_done), .arg_count(out_arg_count), .last(out_last)
  );

endmodule
